// ===== hw/rtl/besu_pkg.sv =====
`timescale 1ns / 1ps

package besu_pkg;

	// Sizes of the stack and the variable file.
	localparam int STACK_DEPTH    = 32;
	localparam int VARIABLE_COUNT = 26;

	// Field widths.
	localparam int WORD_W  = 32;
	localparam int CMD_W   = 4;
	localparam int ERR_W   = 3;
	localparam int DEPTH_W = 6;

	// Derived widths.
	localparam int SP_W   = $clog2(STACK_DEPTH + 1);
	localparam int SPX_W  = SP_W + 3;
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int VAR_W  = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;
	localparam int CNT_W  = $clog2(WORD_W);

	// Command codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH     = 4'd0,
		CMD_ADD      = 4'd1,
		CMD_SUB      = 4'd2,
		CMD_NEG      = 4'd3,
		CMD_MUL      = 4'd4,
		CMD_DIV      = 4'd5,
		CMD_STORE    = 4'd6,
		CMD_LOAD     = 4'd7,
		CMD_COMPARE  = 4'd8,
		CMD_POP      = 4'd9,
		CMD_CLR_STK  = 4'd10,
		CMD_CLR_VARS = 4'd11
	} cmd_t;

	// Error codes.
	typedef enum logic [ERR_W-1:0] {
		ERR_OK    = 3'd0,
		ERR_UNDER = 3'd1,
		ERR_OVER  = 3'd2,
		ERR_DIVZ  = 3'd3,
		ERR_REL   = 3'd4,
		ERR_INDEX = 3'd5
	} err_t;

	// Relation codes of the compare command.
	typedef enum logic [2:0] {
		REL_EQ = 3'd0,
		REL_LT = 3'd1,
		REL_LE = 3'd2,
		REL_NE = 3'd3,
		REL_GT = 3'd4,
		REL_GE = 3'd5
	} rel_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_BELOW,
		ST_RD_THIRD,
		ST_DIV,
		ST_EXEC
	} state_t;

	// Which stack entry the read port addresses, counted from the top.
	typedef enum logic [1:0] {
		RD_BELOW,
		RD_THIRD,
		RD_FOURTH
	} rd_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    capture;
		rd_sel_t rd_sel;
		logic    cap_below;
		logic    cap_third;
		logic    div_start;
		logic    commit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_go;
		logic div_busy;
		logic out_full;
	} dp_status_t;

endpackage

// ===== hw/rtl/besu_if.sv =====
`timescale 1ns / 1ps

// Command channel: one command word per handshake.
interface besu_cmd_if;
	import besu_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic signed [WORD_W-1:0] value;

	modport source (output valid, command, value, input ready);
	modport sink (input valid, command, value, output ready);
endinterface

// Result channel: one result word per command.
interface besu_res_if;
	import besu_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] top_value;
	logic signed [WORD_W-1:0] popped_value;
	logic                     condition_true;
	logic [ERR_W-1:0]         error_code;
	logic [DEPTH_W-1:0]       stack_depth;

	modport source (output valid, top_value, popped_value, condition_true, error_code,
		stack_depth, input ready);
	modport sink (input valid, top_value, popped_value, condition_true, error_code,
		stack_depth, output ready);
endinterface

// ===== hw/rtl/besu_div.sv =====
`timescale 1ns / 1ps

// Radix-2 restoring divider on magnitudes, one quotient bit per cycle,
// with the sign applied to the truncated quotient at the end.
module besu_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [besu_pkg::WORD_W-1:0]   dividend,
	input  logic [besu_pkg::WORD_W-1:0]   divisor,
	output logic                          busy,
	output logic [besu_pkg::WORD_W-1:0]   quotient
);
	import besu_pkg::*;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] den_q;
	logic              neg_q;
	logic [WORD_W:0]   shifted;
	logic [WORD_W:0]   diff;

	// Trial subtraction of the divisor from the shifted remainder.
	assign shifted = {rem_q, quo_q[WORD_W-1]};
	assign diff    = shifted - {1'b0, den_q};

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(WORD_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
			den_q <= divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
			neg_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
		end else if (busy_q) begin
			if (!diff[WORD_W]) begin
				rem_q <= diff[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = neg_q ? (WORD_W'(0) - quo_q) : quo_q;

endmodule

// ===== hw/rtl/besu_ctrl.sv =====
`timescale 1ns / 1ps

// Sequencer: accepts a command word, steps the stack reads, waits on the
// divider when needed and commits the result once the output register frees.
module besu_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  besu_pkg::dp_status_t   sts,
	output besu_pkg::ctrl_cmd_t    ctl
);
	import besu_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_RD_BELOW;
				end
			end
			ST_RD_BELOW: begin
				state_nxt = ST_RD_THIRD;
			end
			ST_RD_THIRD: begin
				state_nxt = sts.div_go ? ST_DIV : ST_EXEC;
			end
			ST_DIV: begin
				if (!sts.div_busy) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!sts.out_full) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready      = 1'b0;
		ctl           = '0;
		ctl.rd_sel    = RD_FOURTH;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				ctl.capture = in_valid;
				ctl.rd_sel  = RD_BELOW;
			end
			ST_RD_BELOW: begin
				ctl.cap_below = 1'b1;
				ctl.rd_sel    = RD_THIRD;
			end
			ST_RD_THIRD: begin
				ctl.cap_third = 1'b1;
				ctl.div_start = sts.div_go;
			end
			ST_DIV: begin
			end
			ST_EXEC: begin
				ctl.commit = !sts.out_full;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/besu_dp.sv =====
`timescale 1ns / 1ps

// Datapath: top-of-stack register, stack memory for the deeper entries,
// variable file, arithmetic, divider and the result register.
module besu_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  besu_pkg::ctrl_cmd_t                ctl,
	output besu_pkg::dp_status_t               sts,
	input  logic [besu_pkg::CMD_W-1:0]         command,
	input  logic signed [besu_pkg::WORD_W-1:0] value,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic signed [besu_pkg::WORD_W-1:0] top_value,
	output logic signed [besu_pkg::WORD_W-1:0] popped_value,
	output logic                               condition_true,
	output logic [besu_pkg::ERR_W-1:0]         error_code,
	output logic [besu_pkg::DEPTH_W-1:0]       stack_depth
);
	import besu_pkg::*;

	logic [CMD_W-1:0]         cmd_q;
	logic [WORD_W-1:0]        val_q;
	logic [SP_W-1:0]          sp_q;
	logic [WORD_W-1:0]        top_q;
	logic [WORD_W-1:0]        below_q;
	logic [WORD_W-1:0]        third_q;
	logic [WORD_W-1:0]        rd_q;
	logic [WORD_W-1:0]        stk_mem [STACK_DEPTH];
	logic [ADDR_W-1:0]        rd_addr;
	logic [SPX_W-1:0]         sp_x;
	logic [WORD_W-1:0]        var_mem [VARIABLE_COUNT];
	logic [VARIABLE_COUNT-1:0] var_vld_q;
	logic [WORD_W-1:0]        var_rd_q;
	logic                     var_vld_rd_q;
	logic [WORD_W-1:0]        var_val;
	logic [WORD_W-1:0]        quotient;
	logic                     div_busy;
	logic                     out_valid_q;

	// Execution results.
	logic [SPX_W-1:0]         need;
	logic [WORD_W-1:0]        nxt_top;
	logic [SP_W-1:0]          nxt_sp;
	logic [WORD_W-1:0]        popped;
	logic                     cond;
	err_t                     err;
	logic                     stk_wr;
	logic                     var_wr;
	logic                     var_clr;
	logic                     rel_hold;
	logic [WORD_W-1:0]        product;

	assign sp_x = SPX_W'(sp_q);

	// Command capture at acceptance, and capture of the second and third entries as they are read.
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q <= command;
			val_q <= value;
		end
		if (ctl.cap_below) begin
			below_q <= rd_q;
		end
		if (ctl.cap_third) begin
			third_q <= rd_q;
		end
	end

	// Stack read address, counted down from the entry count.
	always_comb begin
		rd_addr = '0;
		unique case (ctl.rd_sel)
			RD_BELOW: begin
				if (sp_x >= SPX_W'(2)) begin
					rd_addr = ADDR_W'(sp_x - SPX_W'(2));
				end
			end
			RD_THIRD: begin
				if (sp_x >= SPX_W'(3)) begin
					rd_addr = ADDR_W'(sp_x - SPX_W'(3));
				end
			end
			RD_FOURTH: begin
				if (sp_x >= SPX_W'(4)) begin
					rd_addr = ADDR_W'(sp_x - SPX_W'(4));
				end
			end
			default: begin
			end
		endcase
	end

	// Stack memory: the top lives in top_q, deeper entries here.
	always_ff @(posedge clk) begin
		if (ctl.commit && stk_wr) begin
			stk_mem[ADDR_W'(sp_x - SPX_W'(1))] <= top_q;
		end
		rd_q <= stk_mem[rd_addr];
	end

	// Variable file memory, addressed by the top for loads.
	always_ff @(posedge clk) begin
		if (ctl.commit && var_wr) begin
			var_mem[below_q[VAR_W-1:0]] <= top_q;
		end
		var_rd_q     <= var_mem[top_q[VAR_W-1:0]];
		var_vld_rd_q <= var_vld_q[top_q[VAR_W-1:0]];
	end

	// Variable valid bits; an entry never written since a clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_vld_q <= '0;
		end else if (ctl.commit && var_clr) begin
			var_vld_q <= '0;
		end else if (ctl.commit && var_wr) begin
			var_vld_q[below_q[VAR_W-1:0]] <= 1'b1;
		end
	end

	assign var_val = var_vld_rd_q ? var_rd_q : '0;

	// Divider works on the entry below over the top.
	besu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (below_q),
		.divisor  (top_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	assign product = below_q * top_q;

	// Relation test of the compare command: third entry against the top.
	always_comb begin
		rel_hold = 1'b0;
		unique case (below_q[2:0])
			REL_EQ:  rel_hold = (third_q == top_q);
			REL_LT:  rel_hold = ($signed(third_q) < $signed(top_q));
			REL_LE:  rel_hold = !($signed(top_q) < $signed(third_q));
			REL_NE:  rel_hold = (third_q != top_q);
			REL_GT:  rel_hold = ($signed(top_q) < $signed(third_q));
			REL_GE:  rel_hold = !($signed(third_q) < $signed(top_q));
			default: rel_hold = 1'b0;
		endcase
	end

	// Operand count each command needs.
	always_comb begin
		need = '0;
		unique case (cmd_q)
			CMD_NEG, CMD_LOAD, CMD_POP: need = SPX_W'(1);
			CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_STORE: need = SPX_W'(2);
			CMD_COMPARE: need = SPX_W'(3);
			default: need = '0;
		endcase
	end

	// Command execution; any error keeps the stack and variables as they are.
	always_comb begin
		nxt_top = top_q;
		nxt_sp  = sp_q;
		popped  = '0;
		cond    = 1'b0;
		err     = ERR_OK;
		stk_wr  = 1'b0;
		var_wr  = 1'b0;
		var_clr = 1'b0;
		if (sp_x < need) begin
			err = ERR_UNDER;
		end else begin
			unique case (cmd_q)
				CMD_PUSH: begin
					if (sp_q == SP_W'(STACK_DEPTH)) begin
						err = ERR_OVER;
					end else begin
						stk_wr  = (sp_q != '0);
						nxt_top = val_q;
						nxt_sp  = sp_q + SP_W'(1);
					end
				end
				CMD_ADD: begin
					nxt_top = below_q + top_q;
					nxt_sp  = sp_q - SP_W'(1);
				end
				CMD_SUB: begin
					nxt_top = below_q - top_q;
					nxt_sp  = sp_q - SP_W'(1);
				end
				CMD_NEG: begin
					nxt_top = WORD_W'(0) - top_q;
				end
				CMD_MUL: begin
					nxt_top = product;
					nxt_sp  = sp_q - SP_W'(1);
				end
				CMD_DIV: begin
					if (top_q == '0) begin
						err = ERR_DIVZ;
					end else begin
						nxt_top = quotient;
						nxt_sp  = sp_q - SP_W'(1);
					end
				end
				CMD_STORE: begin
					if (below_q[WORD_W-1] || (below_q >= WORD_W'(VARIABLE_COUNT))) begin
						err = ERR_INDEX;
					end else begin
						var_wr  = 1'b1;
						nxt_top = third_q;
						nxt_sp  = sp_q - SP_W'(2);
					end
				end
				CMD_LOAD: begin
					if (top_q[WORD_W-1] || (top_q >= WORD_W'(VARIABLE_COUNT))) begin
						err = ERR_INDEX;
					end else begin
						nxt_top = var_val;
					end
				end
				CMD_COMPARE: begin
					if (below_q > WORD_W'(REL_GE)) begin
						err = ERR_REL;
					end else begin
						cond    = rel_hold;
						nxt_top = rd_q;
						nxt_sp  = sp_q - SP_W'(3);
					end
				end
				CMD_POP: begin
					popped  = top_q;
					nxt_top = below_q;
					nxt_sp  = sp_q - SP_W'(1);
				end
				CMD_CLR_STK: begin
					nxt_sp = '0;
				end
				CMD_CLR_VARS: begin
					var_clr = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Stack pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (ctl.commit) begin
			sp_q <= nxt_sp;
		end
	end

	// Top of stack.
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			top_q <= nxt_top;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			top_value      <= (nxt_sp != '0) ? nxt_top : '0;
			popped_value   <= popped;
			condition_true <= cond;
			error_code     <= err;
			stack_depth    <= DEPTH_W'(nxt_sp);
		end
	end

	assign res_valid    = out_valid_q;
	assign sts.div_go   = (cmd_q == CMD_DIV) && (sp_x >= SPX_W'(2)) && (top_q != '0);
	assign sts.div_busy = div_busy;
	assign sts.out_full = out_valid_q && !res_ready;

endmodule

// ===== hw/rtl/basic_expression_stack_unit.sv =====
`timescale 1ns / 1ps

// Expression stack and variable file of a small BASIC interpreter machine.
// Channel cmd carries one command word (command, value); channel res returns
// exactly one result word per command (top_value, popped_value,
// condition_true, error_code, stack_depth). Both use valid/ready.
// Sequence: the accept step, two reads of the single stack memory read port
// (the second and third entries from the top; the fourth is read in the last
// of these and is ready for execution) and the execute step, which commits the
// result word to the output register. A divide waits for the one-bit-per-cycle
// divider before its execute step. A new command is taken only once the last
// one has been committed.
// Reset clears the stack depth, the variable file (through per-entry valid
// bits) and the result valid flag; the stack memory itself is not cleared,
// since an entry is only read after it has been written.
// When the receiver stalls, the result word holds in the output register; the
// next command is still accepted and worked, and waits in its execute cycle
// until the output register is free.
module basic_expression_stack_unit (
	input logic        clk,
	input logic        arst_n,
	besu_cmd_if.sink   cmd,
	besu_res_if.source res
);
	import besu_pkg::*;

	ctrl_cmd_t  ctl;
	dp_status_t sts;

	besu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	besu_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.command        (cmd.command),
		.value          (cmd.value),
		.res_valid      (res.valid),
		.res_ready      (res.ready),
		.top_value      (res.top_value),
		.popped_value   (res.popped_value),
		.condition_true (res.condition_true),
		.error_code     (res.error_code),
		.stack_depth    (res.stack_depth)
	);

endmodule

// ===== hw/rtl/besu_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks of the expression stack unit.
module besu_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cmd_valid,
	input logic                               cmd_ready,
	input logic                               res_valid,
	input logic                               res_ready,
	input logic signed [besu_pkg::WORD_W-1:0] top_value,
	input logic signed [besu_pkg::WORD_W-1:0] popped_value,
	input logic                               condition_true,
	input logic [besu_pkg::ERR_W-1:0]         error_code,
	input logic [besu_pkg::DEPTH_W-1:0]       stack_depth
);
	import besu_pkg::*;

	// A stalled result word holds its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(top_value) &&
		$stable(popped_value) && $stable(error_code) && $stable(stack_depth))
		else $error("stalled result word changed");

	// Commands are worked one at a time: no accept right after an accept.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted in back-to-back cycles");

	// A failed command pops nothing and reports no true condition.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (error_code != ERR_OK) |-> (popped_value == '0) && !condition_true)
		else $error("error result carries pop or compare data");

	// Overflow is only reported with a full stack.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (error_code == ERR_OVER) |-> stack_depth == DEPTH_W'(STACK_DEPTH))
		else $error("overflow reported with room on the stack");

endmodule

bind basic_expression_stack_unit besu_checker u_besu_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.top_value      (res.top_value),
	.popped_value   (res.popped_value),
	.condition_true (res.condition_true),
	.error_code     (res.error_code),
	.stack_depth    (res.stack_depth)
);

// ===== tb/basic_expression_stack_unit_tb.sv =====
`timescale 1ns / 1ps

module basic_expression_stack_unit_tb;
	import besu_pkg::*;

	// Command codes that the block ignores, and the first relation code it rejects.
	localparam logic [CMD_W-1:0]  CMD_FIRST_UNUSED   = 4'd12;
	localparam logic [WORD_W-1:0] FIRST_BAD_RELATION = 32'd6;
	localparam logic [WORD_W-1:0] MOST_NEGATIVE      = 32'h8000_0000;
	localparam logic [WORD_W-1:0] MOST_POSITIVE      = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] ALL_ONES           = 32'hffff_ffff;

	typedef struct packed {
		logic [WORD_W-1:0]  top_value;
		logic [WORD_W-1:0]  popped_value;
		logic               condition_true;
		logic [ERR_W-1:0]   error_code;
		logic [DEPTH_W-1:0] stack_depth;
	} stack_result_t;

	logic clk = 1'b0;
	logic arst_n;

	besu_cmd_if cmd_bus ();
	besu_res_if res_bus ();

	basic_expression_stack_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.res    (res_bus)
	);

	always #2 clk = ~clk;

	// Predicted state of the stack and the variable file.
	logic [WORD_W-1:0] word_stack [STACK_DEPTH];
	logic [WORD_W-1:0] var_file [VARIABLE_COUNT];
	int stack_level = 0;

	stack_result_t expected_results [$];

	bit source_idles = 1'b1;
	bit sink_idles = 1'b1;
	int hold_request = 0;
	int words_sent = 0;
	int results_checked = 0;
	int true_conditions = 0;
	int outcome_count [8];
	int mismatch_count = 0;

	// Work out the result of one command and update the predicted state.
	function automatic stack_result_t apply_command(input logic [CMD_W-1:0] op,
		input logic [WORD_W-1:0] operand);
		stack_result_t r;
		int need;
		int level;
		logic [WORD_W-1:0] t, b, a, mag_n, mag_d, quo;
		logic holds;
		r = '0;
		r.error_code = ERR_OK;
		level = stack_level;
		holds = 1'b0;
		case (op)
			CMD_NEG, CMD_LOAD, CMD_POP: need = 1;
			CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_STORE: need = 2;
			CMD_COMPARE: need = 3;
			default: need = 0;
		endcase
		if (level < need) begin
			r.error_code = ERR_UNDER;
		end else begin
			t = (level >= 1) ? word_stack[level - 1] : '0;
			b = (level >= 2) ? word_stack[level - 2] : '0;
			case (op)
				CMD_PUSH: begin
					if (level >= STACK_DEPTH) begin
						r.error_code = ERR_OVER;
					end else begin
						word_stack[level] = operand;
						level++;
					end
				end
				CMD_ADD: begin
					word_stack[level - 2] = b + t;
					level--;
				end
				CMD_SUB: begin
					word_stack[level - 2] = b - t;
					level--;
				end
				CMD_NEG: word_stack[level - 1] = '0 - t;
				CMD_MUL: begin
					word_stack[level - 2] = b * t;
					level--;
				end
				CMD_DIV: begin
					// Divide magnitudes, then fix the sign; this truncates toward zero
					// and wraps the most negative value over minus one.
					if (t == '0) begin
						r.error_code = ERR_DIVZ;
					end else begin
						mag_n = b[WORD_W-1] ? '0 - b : b;
						mag_d = t[WORD_W-1] ? '0 - t : t;
						quo = mag_n / mag_d;
						word_stack[level - 2] = (b[WORD_W-1] != t[WORD_W-1]) ? '0 - quo : quo;
						level--;
					end
				end
				CMD_STORE: begin
					if (b[WORD_W-1] || b >= VARIABLE_COUNT) begin
						r.error_code = ERR_INDEX;
					end else begin
						var_file[b[VAR_W-1:0]] = t;
						level -= 2;
					end
				end
				CMD_LOAD: begin
					if (t[WORD_W-1] || t >= VARIABLE_COUNT)
						r.error_code = ERR_INDEX;
					else
						word_stack[level - 1] = var_file[t[VAR_W-1:0]];
				end
				CMD_COMPARE: begin
					// The third entry is the left operand, the second the relation.
					a = word_stack[level - 3];
					case (b)
						REL_EQ: holds = (a == t);
						REL_LT: holds = ($signed(a) < $signed(t));
						REL_LE: holds = ($signed(a) <= $signed(t));
						REL_NE: holds = (a != t);
						REL_GT: holds = ($signed(a) > $signed(t));
						REL_GE: holds = ($signed(a) >= $signed(t));
						default: r.error_code = ERR_REL;
					endcase
					if (r.error_code == ERR_OK) begin
						r.condition_true = holds;
						level -= 3;
					end
				end
				CMD_POP: begin
					r.popped_value = t;
					level--;
				end
				CMD_CLR_STK: level = 0;
				CMD_CLR_VARS: begin
					foreach (var_file[i])
						var_file[i] = '0;
				end
				default: ;
			endcase
		end
		stack_level = level;
		r.top_value = (level >= 1) ? word_stack[level - 1] : '0;
		r.stack_depth = level[DEPTH_W-1:0];
		return r;
	endfunction

	// Operands lean toward the extremes and small values so that zero divisors,
	// wrap cases and equal compares come up often.
	function automatic logic [WORD_W-1:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return MOST_NEGATIVE;
			1: return MOST_POSITIVE;
			2: return ALL_ONES;
			3: return '0;
			4, 5: return WORD_W'($urandom_range(0, 20)) - WORD_W'(10);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] pick_index();
		case ($urandom_range(0, 9))
			0: return WORD_W'(VARIABLE_COUNT);
			1: return $urandom();
			2: return ALL_ONES;
			default: return WORD_W'($urandom_range(0, VARIABLE_COUNT - 1));
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] pick_relation();
		case ($urandom_range(0, 9))
			0: return FIRST_BAD_RELATION;
			1: return $urandom();
			default: return WORD_W'($urandom_range(REL_EQ, REL_GE));
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("mismatch at %0t ns: %s", $time, what);
	endtask

	// Offer one command word, with an occasional idle burst first, and record its
	// expected result once the block takes it.
	task automatic send_word(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] operand);
		int gap;
		if (source_idles && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid   <= 1'b1;
		cmd_bus.command <= op;
		cmd_bus.value   <= operand;
		@(posedge clk);
		while (!cmd_bus.ready)
			@(posedge clk);
		expected_results.push_back(apply_command(op, operand));
		words_sent++;
	endtask

	task automatic wait_for_results();
		cmd_bus.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Result side: random stalls, and long hold-offs on request.
	initial begin : result_sink
		int n;
		forever begin
			if (hold_request != 0) begin
				n = hold_request;
				hold_request = 0;
				res_bus.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (sink_idles && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 7);
				res_bus.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				res_bus.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Compare each accepted result word with the oldest prediction.
	always @(posedge clk) begin : result_checker
		stack_result_t got, want;
		if (arst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
			got.top_value = res_bus.top_value;
			got.popped_value = res_bus.popped_value;
			got.condition_true = res_bus.condition_true;
			got.error_code = res_bus.error_code;
			got.stack_depth = res_bus.stack_depth;
			if (expected_results.size() == 0) begin
				report_mismatch("result word with no command waiting");
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				outcome_count[want.error_code]++;
				if (want.condition_true)
					true_conditions++;
				if (got.top_value !== want.top_value)
					report_mismatch($sformatf("top_value %h, expected %h",
						got.top_value, want.top_value));
				if (got.popped_value !== want.popped_value)
					report_mismatch($sformatf("popped_value %h, expected %h",
						got.popped_value, want.popped_value));
				if (got.condition_true !== want.condition_true)
					report_mismatch($sformatf("condition_true %b, expected %b",
						got.condition_true, want.condition_true));
				if (got.error_code !== want.error_code)
					report_mismatch($sformatf("error_code %0d, expected %0d",
						got.error_code, want.error_code));
				if (got.stack_depth !== want.stack_depth)
					report_mismatch($sformatf("stack_depth %0d, expected %0d",
						got.stack_depth, want.stack_depth));
			end
		end
	end

	// Commands that need entries, sent to an empty stack.
	task automatic test_empty_stack();
		send_word(CMD_POP, MOST_POSITIVE);
		send_word(CMD_COMPARE, '0);
	endtask

	// Wrapping divide and negate, zero divisor, and every arithmetic command.
	task automatic test_arithmetic_wrap();
		send_word(CMD_PUSH, MOST_NEGATIVE);
		send_word(CMD_PUSH, ALL_ONES);
		send_word(CMD_DIV, '0);
		send_word(CMD_NEG, '0);
		send_word(CMD_PUSH, '0);
		send_word(CMD_DIV, '0);
		send_word(CMD_MUL, '0);
		send_word(CMD_PUSH, MOST_POSITIVE);
		send_word(CMD_SUB, '0);
		send_word(CMD_PUSH, ALL_ONES);
		send_word(CMD_ADD, '0);
		send_word(CMD_POP, '0);
	endtask

	// Highest variable, an index just past the end, a bad relation code and an
	// ignored command code.
	task automatic test_variables_and_relations();
		send_word(CMD_PUSH, WORD_W'(VARIABLE_COUNT - 1));
		send_word(CMD_PUSH, MOST_POSITIVE);
		send_word(CMD_STORE, '0);
		send_word(CMD_PUSH, WORD_W'(VARIABLE_COUNT - 1));
		send_word(CMD_LOAD, '0);
		send_word(CMD_PUSH, WORD_W'(VARIABLE_COUNT));
		send_word(CMD_LOAD, '0);
		send_word(CMD_CLR_VARS, '0);
		send_word(CMD_PUSH, FIRST_BAD_RELATION);
		send_word(CMD_PUSH, WORD_W'(1));
		send_word(CMD_COMPARE, '0);
		send_word(CMD_FIRST_UNUSED + CMD_W'($urandom_range(0, 3)), $urandom());
		send_word(CMD_CLR_STK, '0);
	endtask

	// Fill the stack while results are held back, overflow it, then empty it.
	task automatic test_backpressure_and_full_stack();
		int i;
		wait_for_results();
		send_word(CMD_CLR_STK, '0);
		hold_request = 120;
		for (i = 0; i <= STACK_DEPTH; i++)
			send_word(CMD_PUSH, pick_operand());
		wait_for_results();
		for (i = 0; i <= STACK_DEPTH; i++)
			send_word(CMD_POP, '0);
	endtask

	// One short command sequence: mostly well formed, sometimes noise.
	task automatic run_random_program();
		int kind, i;
		logic [CMD_W-1:0] op;
		logic [WORD_W-1:0] left;
		if (stack_level > STACK_DEPTH - 6) begin
			if ($urandom_range(0, 1) != 0)
				send_word(CMD_CLR_STK, pick_operand());
			else
				send_word(CMD_POP, pick_operand());
			return;
		end
		kind = $urandom_range(0, 15);
		case (kind)
			0, 1, 2, 3: begin
				if (stack_level < 2 || $urandom_range(0, 1) != 0)
					send_word(CMD_PUSH, pick_operand());
				send_word(CMD_PUSH, pick_operand());
				case ($urandom_range(0, 3))
					0: op = CMD_ADD;
					1: op = CMD_SUB;
					2: op = CMD_MUL;
					default: op = CMD_DIV;
				endcase
				send_word(op, pick_operand());
				if ($urandom_range(0, 3) == 0)
					send_word(CMD_NEG, pick_operand());
			end
			4, 5, 6: begin
				left = pick_operand();
				send_word(CMD_PUSH, left);
				send_word(CMD_PUSH, pick_relation());
				send_word(CMD_PUSH, ($urandom_range(0, 2) == 0) ? left : pick_operand());
				send_word(CMD_COMPARE, pick_operand());
			end
			7, 8: begin
				send_word(CMD_PUSH, pick_index());
				send_word(CMD_PUSH, pick_operand());
				send_word(CMD_STORE, pick_operand());
			end
			9, 10: begin
				send_word(CMD_PUSH, pick_index());
				send_word(CMD_LOAD, pick_operand());
				if ($urandom_range(0, 1) != 0)
					send_word(CMD_POP, pick_operand());
			end
			11: send_word(CMD_POP, pick_operand());
			12: send_word(CMD_W'($urandom_range(0, (1 << CMD_W) - 1)), $urandom());
			13: send_word(CMD_CLR_STK, pick_operand());
			14: begin
				if ($urandom_range(0, 3) == 0)
					send_word(CMD_CLR_VARS, pick_operand());
				else
					send_word(CMD_LOAD, pick_operand());
			end
			default: begin
				if ($urandom_range(0, 3) == 0) begin
					while (stack_level < STACK_DEPTH)
						send_word(CMD_PUSH, pick_operand());
					send_word(CMD_PUSH, pick_operand());
					send_word(CMD_CLR_STK, '0);
				end else begin
					for (i = 0; i < 2; i++)
						send_word(CMD_FIRST_UNUSED + CMD_W'($urandom_range(0, 3)), $urandom());
				end
			end
		endcase
	endtask

	// Random sequences in stretches, each with its own idling on either side.
	task automatic test_random_programs(input int target);
		while (words_sent < target) begin
			source_idles = ($urandom_range(0, 2) != 0);
			sink_idles = ($urandom_range(0, 2) != 0);
			repeat (12)
				run_random_program();
		end
	endtask

	// Closing stretch with both sides running flat out.
	task automatic test_quiet_tail(input int target);
		source_idles = 1'b0;
		sink_idles = 1'b0;
		while (words_sent < target)
			run_random_program();
	endtask

	initial begin : run_limit
		#(2_000_000);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : main_sequence
		arst_n <= 1'b0;
		cmd_bus.valid <= 1'b0;
		cmd_bus.command <= CMD_PUSH;
		cmd_bus.value <= '0;
		foreach (word_stack[i])
			word_stack[i] = '0;
		foreach (var_file[i])
			var_file[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_stack();
		test_arithmetic_wrap();
		test_variables_and_relations();
		test_backpressure_and_full_stack();
		test_random_programs(360);
		test_quiet_tail(420);

		wait_for_results();
		repeat (60) @(posedge clk);

		$display("Sent %0d commands and checked %0d results; %0d compares held.",
			words_sent, results_checked, true_conditions);
		$display("Outcomes ok/under/over/divzero/relation/index: %0d/%0d/%0d/%0d/%0d/%0d",
			outcome_count[ERR_OK], outcome_count[ERR_UNDER], outcome_count[ERR_OVER],
			outcome_count[ERR_DIVZ], outcome_count[ERR_REL], outcome_count[ERR_INDEX]);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
